// ===== src/sha_pkg.sv =====
// sha_pkg: shared types and constants for the streaming sha-256 hasher
// used by sha_core and sha256_stream_hasher; no dependencies
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } sha_in_t;

  typedef struct packed {
    logic [63:0] digest_chunk;
    logic [1:0]  chunk_index;
    logic        last_chunk;
  } sha_out_t;

  // control from the top level to the compression core
  typedef struct packed {
    logic start;
    logic first;
  } core_ctl_t;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned amt);
    ror32 = (v >> amt) | (v << (32 - amt));
  endfunction

endpackage

// ===== src/sha_core.sv =====
// sha_core: 64-round sha-256 compression over one 64-byte block
// reads the block from a 16-word schedule memory; depends on sha_pkg
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  core_ctl_t   ctl,
  // block word write port from the top level
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  output logic        busy,
  output logic        done,
  output logic [31:0] hash [8]
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PRE  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_ADD  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  round;
  logic [31:0] wv [8];
  logic [31:0] w15, w2, w7, w16;

  // rolling schedule: four copies so each tap has its own read port
  logic [31:0] mem_a [16];
  logic [31:0] mem_b [16];
  logic [31:0] mem_c [16];
  logic [31:0] mem_d [16];

  logic [5:0]  rd_t;
  logic [31:0] sg0, sg1, w_new, w_cur;
  logic [31:0] big1, chs, t1, big0, mj, t2;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;

  // the round being fetched for the next cycle
  assign rd_t = (state == S_PRE) ? 6'd0 : round + 6'd1;

  assign sg0   = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
  assign sg1   = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
  assign w_new = w16 + sg0 + w7 + sg1;
  assign w_cur = (round >= 6'd16) ? w_new : w16;

  assign mem_we    = wr_en || (state == S_RUN && round >= 6'd16);
  assign mem_waddr = wr_en ? wr_addr : round[3:0];
  assign mem_wdata = wr_en ? wr_data : w_new;

  // schedule memories, registered reads with write forwarding from this round
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[mem_waddr] <= mem_wdata;
      mem_b[mem_waddr] <= mem_wdata;
      mem_c[mem_waddr] <= mem_wdata;
      mem_d[mem_waddr] <= mem_wdata;
    end
    w16 <= (mem_we && mem_waddr == rd_t[3:0]) ? mem_wdata : mem_a[rd_t[3:0]];
    w15 <= (mem_we && mem_waddr == rd_t[3:0] + 4'd1) ? mem_wdata
                                                       : mem_b[rd_t[3:0] + 4'd1];
    w2  <= (mem_we && mem_waddr == rd_t[3:0] - 4'd2) ? mem_wdata
                                                       : mem_c[rd_t[3:0] - 4'd2];
    w7  <= (mem_we && mem_waddr == rd_t[3:0] - 4'd7) ? mem_wdata
                                                       : mem_d[rd_t[3:0] - 4'd7];
  end

  // round function
  assign big1 = ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25);
  assign chs  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign t1   = wv[7] + big1 + chs + RoundK[round] + w_cur;
  assign big0 = ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22);
  assign mj   = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t2   = big0 + mj;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      done  <= 1'b0;
      for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            state <= S_PRE;
            for (int i = 0; i < 8; i++) begin
              wv[i] <= ctl.first ? InitHash[i] : hash[i];
              if (ctl.first) hash[i] <= InitHash[i];
            end
          end
        end
        S_PRE: begin
          state <= S_RUN;
          round <= '0;
        end
        S_RUN: begin
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sha256_stream_hasher.sv =====
// sha256_stream_hasher: byte-stream sha-256 with padding and digest output
// instantiates sha_core; depends on sha_pkg
//
// Takes one byte per word; four bytes are packed into a big-endian schedule
// word held in the core's memory. The sixty-fourth byte of a block starts
// the core, which stalls the input while it runs (a fetch step, 64 rounds,
// an add step). A word with is_last adds padding at one byte per cycle while
// the core is idle (up to 72 bytes, with one or two extra compressions) and
// then gives four 64-bit digest words, most significant first. No clearing
// pass after reset.
module sha256_stream_hasher import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sha_out_t out_data
);

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic [63:0] bit_count;
  logic [5:0]  byte_fill;
  logic [23:0] word_acc;
  logic        first;
  logic        pad_phase;   // set once the pad mark byte has been pushed
  logic [1:0]  chunk;
  logic [31:0] hash [8];
  logic        core_busy, core_done;
  core_ctl_t   ctl;

  logic        push;
  logic [7:0]  push_byte;
  logic        wr_en;
  logic        in_fire;

  assign in_stall = (state != S_IN) || core_busy;
  assign in_fire  = in_valid && !in_stall;

  // pick the byte going into the buffer this cycle
  always_comb begin
    push      = 1'b0;
    push_byte = PadMark;
    case (state)
      S_IN: begin
        push      = in_fire && in_data.has_byte;
        push_byte = in_data.data_byte;
      end
      S_PAD: begin
        push      = !core_busy;
        push_byte = pad_phase ? 8'h00 : PadMark;
      end
      S_LEN: begin
        push      = !core_busy;
        push_byte = bit_count[6'd63 - {byte_fill[2:0], 3'd0} -: 8];
      end
      default: ;
    endcase
  end

  assign wr_en     = push && (byte_fill[1:0] == 2'd3);
  assign ctl.start = push && (byte_fill == 6'd63);
  assign ctl.first = first;

  sha_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_en   (wr_en),
    .wr_addr (byte_fill[5:2]),
    .wr_data ({word_acc, push_byte}),
    .busy    (core_busy),
    .done    (core_done),
    .hash    (hash)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      bit_count <= '0;
      byte_fill <= '0;
      first     <= 1'b1;
      pad_phase <= 1'b0;
      chunk     <= '0;
    end else begin
      if (push) begin
        word_acc  <= {word_acc[15:0], push_byte};
        byte_fill <= byte_fill + 6'd1;
        if (ctl.start) first <= 1'b0;
      end
      case (state)
        S_IN: begin
          if (in_fire) begin
            if (in_data.has_byte) bit_count <= bit_count + 64'd8;
            if (in_data.is_last) begin
              state     <= S_PAD;
              pad_phase <= 1'b0;
            end
          end
        end
        S_PAD: begin
          if (push) begin
            pad_phase <= 1'b1;
            if (byte_fill + 6'd1 == LenPos) state <= S_LEN;
          end
        end
        S_LEN: begin
          if (push && byte_fill == 6'd63) state <= S_WAIT;
        end
        S_WAIT: begin
          if (core_done) begin
            state <= S_OUT;
            chunk <= '0;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            chunk <= chunk + 2'd1;
            if (chunk == 2'd3) begin
              state     <= S_IN;
              bit_count <= '0;
              first     <= 1'b1;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  // digest words straight from the core's hash registers
  assign out_valid = (state == S_OUT);
  assign out_data.digest_chunk = {hash[{chunk, 1'b0}], hash[{chunk, 1'b1}]};
  assign out_data.chunk_index  = chunk;
  assign out_data.last_chunk   = (chunk == 2'd3);

endmodule

// ===== src/sha_checker.sv =====
// sha_checker: port-level checks on the streaming sha-256 hasher
// bound to sha256_stream_hasher; depends on sha_pkg
module sha_checker import sha_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input sha_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input sha_out_t out_data
);

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word changed while stalled");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // chunks come in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_chunk |=>
      out_valid && out_data.chunk_index == $past(out_data.chunk_index) + 2'd1)
    else $error("digest chunk out of order");

  // last flag matches index
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.last_chunk == (out_data.chunk_index == 2'd3))
    else $error("last flag mismatch");

  // no input taken while a digest is being delivered
  a_no_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during digest output");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (.*);

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for sha256_stream_hasher
// depends on sha_pkg and the hasher rtl; byte words in, digest chunks out
`timescale 1ns / 1ps

module tb_top;
  import sha_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sha_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b1;
  sha_out_t out_data;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  localparam int CycleLimit = 2000000;

  // predictor state
  logic [31:0] hw [8];
  logic [7:0]  blk [64];
  logic [63:0] nbits;
  logic [5:0]  fill;

  sha_out_t digest_q [$];
  int       errors = 0;
  int       cycles = 0;
  int       sent = 0;
  bit       long_hold = 0;
  bit       done = 0;

  function automatic logic [31:0] rr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10));
    {a, b, c, d, e, f, g, h} = {hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & f) ^ (~e & g)) + RoundK[t] + w[t];
      t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hw[0] += a; hw[1] += b; hw[2] += c; hw[3] += d;
    hw[4] += e; hw[5] += f; hw[6] += g; hw[7] += h;
  endtask

  task automatic add_byte(input logic [7:0] v);
    blk[fill] = v;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress();
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hw[i] = InitHash[i];
    nbits = '0;
    fill = '0;
  endtask

  // model one accepted word, queue the digest chunks it causes
  task automatic predict_digest(input sha_in_t w);
    logic [63:0] len;
    sha_out_t r;
    if (w.has_byte) begin
      nbits += 64'd8;
      add_byte(w.data_byte);
    end
    if (w.is_last) begin
      len = nbits;
      add_byte(PadMark);
      while (fill != LenPos) add_byte(8'h00);
      for (int k = 0; k < 8; k++) add_byte(len[63-8*k -: 8]);
      for (int k = 0; k < 4; k++) begin
        r.digest_chunk = {hw[2*k], hw[2*k+1]};
        r.chunk_index = k[1:0];
        r.last_chunk = (k == 3);
        digest_q = {digest_q, r};
      end
      restart_hash();
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // directed table; the empty message digest is known at a glance
  typedef struct {
    sha_in_t     w;
    bit          known;
    logic [63:0] first_chunk;
  } row_t;
  row_t rows [$];

  task automatic add_row(input logic [7:0] b, input bit hb, input bit lst,
                         input bit kn = 0, input logic [63:0] fc = '0);
    row_t r;
    r.w = '{data_byte: b, has_byte: hb, is_last: lst};
    r.known = kn;
    r.first_chunk = fc;
    rows = {rows, r};
  endtask

  logic [63:0] known_q [$];

  // send one word after a random gap; valid stays high for a word back to back
  task automatic send(input sha_in_t w, input bit gap = 1);
    int idle_cycles;
    idle_cycles = gap ? int'($urandom_range(0, 19)) : 0;
    if (idle_cycles != 0) begin
      in_valid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digest(w);
    sent++;
  endtask

  // drop valid and wait on the clock
  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sha_in_t rand_word(input bit lst);
    sha_in_t w;
    w.data_byte = 8'($urandom_range(0, 255));
    w.has_byte = 1'b1;
    w.is_last = lst;
    return w;
  endfunction

  // receiver: random stalls, one long hold on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // check each accepted digest chunk against the oldest expectation
  always @(posedge clk) begin
    sha_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        report("unexpected chunk", out_data.digest_chunk, '0);
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_chunk !== want.digest_chunk)
          report("digest_chunk", out_data.digest_chunk, want.digest_chunk);
        if (out_data.chunk_index !== want.chunk_index)
          report("chunk_index", out_data.chunk_index, want.chunk_index);
        if (out_data.last_chunk !== want.last_chunk)
          report("last_chunk", out_data.last_chunk, want.last_chunk);
        if (want.chunk_index == 2'd0 && known_q.size() != 0) begin
          if (out_data.digest_chunk !== known_q[0])
            report("known digest", out_data.digest_chunk, known_q[0]);
          void'(known_q.pop_front());
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit && !done) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    restart_hash();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, idle words, extremes, byte with last, "abc"
    add_row(8'h00, 0, 1, 1, 64'he3b0c44298fc1c14);
    add_row(8'hff, 0, 0);
    add_row(8'h00, 1, 0);
    add_row(8'hff, 1, 1);
    add_row(8'h61, 1, 0);
    add_row(8'h62, 1, 0);
    add_row(8'h63, 1, 0);
    add_row(8'h00, 0, 1, 1, 64'hba7816bf8f01cfea);
    add_row(8'h55, 1, 0);
    add_row(8'haa, 1, 0);
    add_row(8'h00, 0, 0);
    add_row(8'h3c, 1, 1);
    foreach (rows[i]) begin
      if (rows[i].known) known_q = {known_q, rows[i].first_chunk};
      send(rows[i].w);
    end

    // random messages, lengths mostly short or around the padding boundaries
    for (int m = 0; m < 6 || sent < 150; m++) begin
      int len;
      case ($urandom_range(0, 5))
        0: len = $urandom_range(54, 57);
        1: len = $urandom_range(62, 66);
        2: len = 119 + $urandom_range(0, 2);
        default: len = $urandom_range(0, 20);
      endcase
      // keep the word count near the budget
      if (sent + len > 150) len = (sent < 150) ? 150 - sent : 0;
      if (m == 2) long_hold = 1;
      for (int i = 0; i < len; i++) begin
        // no gaps while the long hold lasts and for the fourth message
        send(rand_word(1'b0), !(long_hold || m == 3));
      end
      // noise: an idle word now and then
      if ($urandom_range(0, 7) == 0)
        send('{data_byte: 8'($urandom), has_byte: 1'b0, is_last: 1'b0});
      if ($urandom_range(0, 1)) begin
        send(rand_word(1'b1));
      end else begin
        send('{data_byte: 8'($urandom), has_byte: 1'b0, is_last: 1'b1});
      end
      // sender pause until the hasher has drained
      if (m == 4) begin
        go_idle();
        while (digest_q.size() != 0) @(posedge clk);
      end
    end

    go_idle();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    done = 1;
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
